[hw/rtl/time_weighted_range_stats_core_defines.svh]
// Assertion macros shared by the checker of the time weighted range statistics core.
// Each macro expands to one labelled concurrent assertion that reports through $error.
`ifndef TIME_WEIGHTED_RANGE_STATS_CORE_DEFINES_SVH
`define TIME_WEIGHTED_RANGE_STATS_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TWRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TWRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define TWRS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/twrs_pkg.sv]
// Package of the time weighted range statistics core: widths, register indexes and
// the command and snapshot types passed between the front, the queue and the back end.
`default_nettype none

package twrs_pkg;

   localparam int TIME_BITS   = 24;
   localparam int VALUE_BITS  = 16;
   localparam int OUT_BITS    = VALUE_BITS + 8;
   localparam int WEIGHT_BITS = TIME_BITS + 1;
   localparam int DEV_BITS    = TIME_BITS + VALUE_BITS + 2;
   localparam int SQ_BITS     = TIME_BITS + 2 * VALUE_BITS + 3;
   localparam int DIFF_BITS   = VALUE_BITS + 1;
   localparam int SQD_BITS    = 2 * VALUE_BITS;
   localparam int SQP_BITS    = SQD_BITS + TIME_BITS;
   localparam int MAG_BITS    = DEV_BITS;
   localparam int NUM_BITS    = MAG_BITS + 8;
   localparam int PROD_BITS   = 2 * MAG_BITS;
   localparam int RAD_BITS    = PROD_BITS + 16;
   localparam int ROOT_BITS   = RAD_BITS / 2;
   localparam int MEAN_BITS   = NUM_BITS + 2;
   localparam int CNT_BITS    = $clog2(NUM_BITS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = TIME_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANGE_START = 1'b0,
      CSR_RANGE_END   = 1'b1
   } twrs_csr_type;

   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   // One unit of work for the back end: an interval to weigh and/or the end of a series.
   typedef struct packed {
      logic                         cnt;
      logic signed [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]         dt;
      logic                         close;
      logic                         found;
   } twrs_cmd_type;

   // Sums of a closed series, handed from the accumulator to the finishing unit.
   typedef struct packed {
      logic                         found;
      logic [WEIGHT_BITS-1:0]       weight;
      logic [DEV_BITS-1:0]          dev;
      logic [SQ_BITS-1:0]           sq;
      logic signed [VALUE_BITS-1:0] ref_value;
      logic signed [VALUE_BITS-1:0] lowest;
      logic signed [VALUE_BITS-1:0] highest;
   } twrs_snap_type;

endpackage

`default_nettype wire

[hw/rtl/twrs_req_if.sv]
// Sample channel of the time weighted range statistics core: valid, ready and one sample.
// Depends on twrs_pkg for the field widths.
`default_nettype none

interface twrs_req_if import twrs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [TIME_BITS-1:0]         sample_time;
   logic signed [VALUE_BITS-1:0] sample_value;
   logic                         value_valid;
   logic                         last_sample;

   modport source (output valid, sample_time, sample_value, value_valid, last_sample,
                   input ready);
   modport sink (input valid, sample_time, sample_value, value_valid, last_sample,
                 output ready);
endinterface

`default_nettype wire

[hw/rtl/twrs_rsp_if.sv]
// Result channel of the time weighted range statistics core: valid, ready and one result.
// Depends on twrs_pkg for the field widths.
`default_nettype none

interface twrs_rsp_if import twrs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         stats_valid;
   logic signed [VALUE_BITS-1:0] lowest;
   logic signed [VALUE_BITS-1:0] highest;
   logic signed [OUT_BITS-1:0]   mean_value;
   logic [OUT_BITS-1:0]          std_value;

   modport source (output valid, stats_valid, lowest, highest, mean_value, std_value,
                   input ready);
   modport sink (input valid, stats_valid, lowest, highest, mean_value, std_value,
                 output ready);
endinterface

`default_nettype wire

[hw/rtl/twrs_front.sv]
// Front end: accepts samples, tracks the held value against the window and turns each
// sample into interval commands for the back end. Depends on twrs_pkg and twrs_req_if.
`default_nettype none

module twrs_front import twrs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   twrs_req_if.sink             req_chan,
   input  logic [TIME_BITS-1:0] range_start,
   input  logic [TIME_BITS-1:0] range_end,
   input  logic                 q_full,
   output logic                 q_push,
   output twrs_cmd_type         q_cmd
);

   logic                         found_ff, found_in;
   logic                         past_end_ff, past_end_in;
   logic signed [VALUE_BITS-1:0] held_value_ff, held_value_in;
   logic                         held_valid_ff, held_valid_in;
   logic [TIME_BITS-1:0]         held_since_ff, held_since_in;
   logic                         pend_ff;
   twrs_cmd_type                 pend_cmd_ff;

   logic                         accept;
   logic                         counting;
   twrs_cmd_type                 acc_cmd;
   twrs_cmd_type                 close_cmd;

   assign req_chan.ready = !pend_ff && !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      found_in      = found_ff;
      past_end_in   = past_end_ff;
      held_value_in = held_value_ff;
      held_valid_in = held_valid_ff;
      held_since_in = held_since_ff;
      counting      = 1'b0;
      if (!past_end_ff) begin
         if (req_chan.sample_time > range_end) begin
            past_end_in = 1'b1;
         end else if (!found_ff) begin
            if (req_chan.sample_time <= range_start) begin
               found_in      = 1'b1;
               held_value_in = req_chan.sample_value;
               held_valid_in = req_chan.value_valid;
               held_since_in = range_start;
            end
         end else begin
            // Time running backwards adds no weight and leaves the hold start in place.
            if (req_chan.sample_time > held_since_ff) begin
               counting      = held_valid_ff;
               held_since_in = req_chan.sample_time;
            end
            held_value_in = req_chan.sample_value;
            held_valid_in = req_chan.value_valid;
         end
      end

      acc_cmd.cnt   = counting;
      acc_cmd.value = held_value_ff;
      acc_cmd.dt    = req_chan.sample_time - held_since_ff;
      acc_cmd.close = 1'b0;
      acc_cmd.found = found_ff;

      close_cmd.cnt   = found_in && held_valid_in && (range_end > held_since_in);
      close_cmd.value = held_value_in;
      close_cmd.dt    = range_end - held_since_in;
      close_cmd.close = 1'b1;
      close_cmd.found = found_in;

      if (pend_ff) begin
         q_push = !q_full;
         q_cmd  = pend_cmd_ff;
      end else begin
         q_push = accept && counting;
         q_cmd  = acc_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         past_end_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         if (accept) begin
            if (req_chan.last_sample) begin
               // The series ends here; its closing command waits in pend_cmd_ff until the queue has room.
               found_ff    <= 1'b0;
               past_end_ff <= 1'b0;
               pend_ff     <= 1'b1;
               pend_cmd_ff <= close_cmd;
            end else begin
               found_ff      <= found_in;
               past_end_ff   <= past_end_in;
               held_value_ff <= held_value_in;
               held_valid_ff <= held_valid_in;
               held_since_ff <= held_since_in;
            end
         end else if (pend_ff && !q_full) begin
            pend_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/twrs_queue.sv]
// Short command queue between the front end and the accumulator.
// Depends on twrs_pkg for the command type and depth.
`default_nettype none

module twrs_queue import twrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  twrs_cmd_type push_cmd,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output twrs_cmd_type head_cmd
);

   twrs_cmd_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS:0]   wr_ptr_ff;
   logic [QPTR_BITS:0]   rd_ptr_ff;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[QPTR_BITS] != rd_ptr_ff[QPTR_BITS]) &&
                     (wr_ptr_ff[QPTR_BITS-1:0] == rd_ptr_ff[QPTR_BITS-1:0]);
   assign head_cmd = slot_ff[rd_ptr_ff[QPTR_BITS-1:0]];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff[QPTR_BITS-1:0]] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/twrs_accum.sv]
// Accumulator: pipeline (p1, p2, p3) that weighs each held value and keeps the running
// extremes, weight, deviation and squared deviation sums. Depends on twrs_pkg.
`default_nettype none

module twrs_accum import twrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  twrs_cmd_type  q_head,
   output logic          q_pop,
   output logic          snap_valid,
   output twrs_snap_type snap,
   input  logic          snap_take
);

   logic                         hold_ff;
   logic                         snap_ff;
   logic                         found_ff;
   logic [WEIGHT_BITS-1:0]       weight_ff;
   logic [DEV_BITS-1:0]          dev_ff;
   logic [SQ_BITS-1:0]           sq_ff;
   logic signed [VALUE_BITS-1:0] ref_ff;
   logic signed [VALUE_BITS-1:0] min_ff;
   logic signed [VALUE_BITS-1:0] max_ff;

   logic                         p1_vld_ff, p1_cnt_ff, p1_close_ff;
   logic signed [DIFF_BITS-1:0]  p1_diff_ff;
   logic [TIME_BITS-1:0]         p1_dt_ff;
   logic                         p2_vld_ff, p2_cnt_ff, p2_close_ff;
   logic signed [DEV_BITS-1:0]   p2_prod_ff;
   logic [SQD_BITS-1:0]          p2_sqd_ff;
   logic [TIME_BITS-1:0]         p2_dt_ff;
   logic                         p3_vld_ff, p3_cnt_ff, p3_close_ff;
   logic [SQP_BITS-1:0]          p3_sqp_ff;

   logic signed [VALUE_BITS-1:0]  ref_in;
   logic signed [DIFF_BITS-1:0]   diff;
   logic signed [DEV_BITS-1:0]    prod_in;
   logic signed [2*DIFF_BITS-1:0] sqd_full;
   logic [SQP_BITS-1:0]           sqp_in;

   // Nothing more is taken from the queue between a close and the hand-over of its sums.
   assign q_pop      = !q_empty && !hold_ff;
   assign snap_valid = snap_ff;

   always_comb begin
      snap.found     = found_ff;
      snap.weight    = weight_ff;
      snap.dev       = dev_ff;
      snap.sq        = sq_ff;
      snap.ref_value = ref_ff;
      snap.lowest    = min_ff;
      snap.highest   = max_ff;

      ref_in   = (weight_ff == '0) ? q_head.value : ref_ff;
      diff     = $signed({q_head.value[VALUE_BITS-1], q_head.value}) -
                 $signed({ref_in[VALUE_BITS-1], ref_in});
      prod_in  = $signed(p1_diff_ff) * $signed({1'b0, p1_dt_ff});
      sqd_full = p1_diff_ff * p1_diff_ff;
      sqp_in   = p2_sqd_ff * p2_dt_ff;
   end

   always_ff @(posedge clock) begin
      p1_cnt_ff   <= q_head.cnt;
      p1_close_ff <= q_head.close;
      p1_diff_ff  <= diff;
      p1_dt_ff    <= q_head.dt;
      p2_cnt_ff   <= p1_cnt_ff;
      p2_close_ff <= p1_close_ff;
      p2_prod_ff  <= prod_in;
      p2_sqd_ff   <= sqd_full[SQD_BITS-1:0];
      p2_dt_ff    <= p1_dt_ff;
      p3_cnt_ff   <= p2_cnt_ff;
      p3_close_ff <= p2_close_ff;
      p3_sqp_ff   <= sqp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         snap_ff   <= 1'b0;
         found_ff  <= 1'b0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         weight_ff <= '0;
         dev_ff    <= '0;
         sq_ff     <= '0;
         ref_ff    <= '0;
         min_ff    <= VALUE_MAX;
         max_ff    <= VALUE_MIN;
      end else begin
         p1_vld_ff <= q_pop;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;

         if (q_pop && q_head.cnt) begin
            ref_ff    <= ref_in;
            weight_ff <= weight_ff + WEIGHT_BITS'(q_head.dt);
            if (q_head.value < min_ff) begin
               min_ff <= q_head.value;
            end
            if (q_head.value > max_ff) begin
               max_ff <= q_head.value;
            end
         end
         if (q_pop && q_head.close) begin
            hold_ff  <= 1'b1;
            found_ff <= q_head.found;
         end
         if (p2_vld_ff && p2_cnt_ff) begin
            dev_ff <= dev_ff + p2_prod_ff;
         end
         if (p3_vld_ff && p3_cnt_ff) begin
            sq_ff <= sq_ff + SQ_BITS'(p3_sqp_ff);
         end
         if (p3_vld_ff && p3_close_ff) begin
            snap_ff <= 1'b1;
         end

         if (snap_ff && snap_take) begin
            snap_ff   <= 1'b0;
            hold_ff   <= 1'b0;
            found_ff  <= 1'b0;
            weight_ff <= '0;
            dev_ff    <= '0;
            sq_ff     <= '0;
            ref_ff    <= '0;
            min_ff    <= VALUE_MAX;
            max_ff    <= VALUE_MIN;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/twrs_final.sv]
// Finishing unit: turns the sums of a closed series into mean and standard deviation
// with a bit-serial divider, multiplier and square root, then holds the result for the
// result channel. Depends on twrs_pkg and twrs_rsp_if.
`default_nettype none

module twrs_final import twrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          snap_valid,
   input  twrs_snap_type snap,
   output logic          snap_take,
   twrs_rsp_if.source    rsp_chan
);

   typedef enum logic [8:0] {
      FIN_IDLE     = 9'b000000001,
      FIN_DIV_MEAN = 9'b000000010,
      FIN_MEAN     = 9'b000000100,
      FIN_MUL_A    = 9'b000001000,
      FIN_MUL_B    = 9'b000010000,
      FIN_SUB      = 9'b000100000,
      FIN_ROOT     = 9'b001000000,
      FIN_DIV_SD   = 9'b010000000,
      FIN_EMIT     = 9'b100000000
   } twrs_fin_state_type;

   twrs_fin_state_type           state_ff;
   logic                         ok_ff;
   logic                         neg_ff;
   logic signed [VALUE_BITS-1:0] ref_ff;
   logic signed [VALUE_BITS-1:0] min_ff;
   logic signed [VALUE_BITS-1:0] max_ff;
   logic [WEIGHT_BITS-1:0]       w_ff;
   logic [SQ_BITS-1:0]           sq_ff;
   logic [MAG_BITS-1:0]          mag_ff;
   logic [NUM_BITS-1:0]          num_ff;
   logic [WEIGHT_BITS-1:0]       rem_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic [MAG_BITS-1:0]          mplr_ff;
   logic [PROD_BITS-1:0]         acc_ff;
   logic [PROD_BITS-1:0]         prod_a_ff;
   logic [RAD_BITS-1:0]          rad_ff;
   logic [ROOT_BITS-1:0]         root_ff;
   logic [ROOT_BITS:0]           srem_ff;
   logic signed [OUT_BITS-1:0]   mean_ff;
   logic [OUT_BITS-1:0]          std_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_ok_ff;
   logic signed [VALUE_BITS-1:0] rsp_min_ff;
   logic signed [VALUE_BITS-1:0] rsp_max_ff;
   logic signed [OUT_BITS-1:0]   rsp_mean_ff;
   logic [OUT_BITS-1:0]          rsp_std_ff;

   logic                         snap_ok;
   logic [MAG_BITS-1:0]          mag_in;
   logic [WEIGHT_BITS:0]         rem_sh;
   logic                         div_ge;
   logic [WEIGHT_BITS:0]         rem_in;
   logic [NUM_BITS-1:0]          num_in;
   logic [PROD_BITS-1:0]         addend;
   logic [PROD_BITS-1:0]         acc_in;
   logic [ROOT_BITS+2:0]         srem_sh;
   logic [ROOT_BITS+2:0]         trial;
   logic                         root_ge;
   logic [ROOT_BITS+2:0]         srem_in;
   logic [ROOT_BITS-1:0]         root_in;
   logic [MEAN_BITS-1:0]         base;
   logic [MEAN_BITS-1:0]         mean_full;
   logic                         mean_fits;
   logic signed [OUT_BITS-1:0]   mean_in;
   logic                         out_free;
   logic                         last_step;

   assign snap_take = snap_valid && (state_ff == FIN_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_step = (cnt_ff == '0);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.stats_valid = rsp_ok_ff;
   assign rsp_chan.lowest      = rsp_min_ff;
   assign rsp_chan.highest     = rsp_max_ff;
   assign rsp_chan.mean_value  = rsp_mean_ff;
   assign rsp_chan.std_value   = rsp_std_ff;

   always_comb begin
      snap_ok = snap.found && (snap.weight != '0);
      mag_in  = snap.dev[DEV_BITS-1] ? (~snap.dev + DEV_BITS'(1)) : snap.dev;

      // Restoring division, one quotient bit a cycle; the quotient shifts into num_ff.
      rem_sh = {rem_ff, num_ff[NUM_BITS-1]};
      div_ge = (rem_sh >= {1'b0, w_ff});
      rem_in = div_ge ? (rem_sh - {1'b0, w_ff}) : rem_sh;
      num_in = {num_ff[NUM_BITS-2:0], div_ge};

      // Shift-and-add multiplication, multiplier bits taken from the top.
      addend = (state_ff == FIN_MUL_A) ? PROD_BITS'(sq_ff) : PROD_BITS'(mag_ff);
      acc_in = {acc_ff[PROD_BITS-2:0], 1'b0} + (mplr_ff[MAG_BITS-1] ? addend : '0);

      // Digit-by-digit square root, two radicand bits a cycle. The partial remainder
      // can reach twice the partial root, so it keeps one bit more than the root.
      srem_sh = {srem_ff, rad_ff[RAD_BITS-1:RAD_BITS-2]};
      trial   = {1'b0, root_ff, 2'b01};
      root_ge = (srem_sh >= trial);
      srem_in = root_ge ? (srem_sh - trial) : srem_sh;
      root_in = {root_ff[ROOT_BITS-2:0], root_ge};

      // A negative deviation sum needs the quotient rounded up so the mean is floored.
      base      = {{(MEAN_BITS-VALUE_BITS-8){ref_ff[VALUE_BITS-1]}}, ref_ff, 8'b0};
      mean_full = neg_ff ? (base - MEAN_BITS'(num_ff) - MEAN_BITS'(rem_ff != '0))
                         : (base + MEAN_BITS'(num_ff));
      mean_fits = (mean_full[MEAN_BITS-1:OUT_BITS-1] == '0) ||
                  (mean_full[MEAN_BITS-1:OUT_BITS-1] == '1);
      if (mean_fits) begin
         mean_in = mean_full[OUT_BITS-1:0];
      end else if (mean_full[MEAN_BITS-1]) begin
         mean_in = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         mean_in = {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         FIN_IDLE: begin
            ok_ff  <= snap_ok;
            neg_ff <= snap.dev[DEV_BITS-1];
            ref_ff <= snap.ref_value;
            min_ff <= snap_ok ? snap.lowest : '0;
            max_ff <= snap_ok ? snap.highest : '0;
            w_ff   <= snap.weight;
            sq_ff  <= snap.sq;
            mag_ff <= mag_in;
            num_ff <= {mag_in, 8'b0};
            rem_ff <= '0;
            cnt_ff <= CNT_BITS'(NUM_BITS - 1);
            mean_ff <= '0;
            std_ff  <= '0;
         end
         FIN_DIV_MEAN: begin
            num_ff <= num_in;
            rem_ff <= rem_in[WEIGHT_BITS-1:0];
            cnt_ff <= cnt_ff - 1'b1;
         end
         FIN_MEAN: begin
            mean_ff <= mean_in;
            acc_ff  <= '0;
            mplr_ff <= {w_ff, {(MAG_BITS-WEIGHT_BITS){1'b0}}};
            cnt_ff  <= CNT_BITS'(WEIGHT_BITS - 1);
         end
         FIN_MUL_A: begin
            if (last_step) begin
               prod_a_ff <= acc_in;
               acc_ff    <= '0;
               mplr_ff   <= mag_ff;
               cnt_ff    <= CNT_BITS'(MAG_BITS - 1);
            end else begin
               acc_ff  <= acc_in;
               mplr_ff <= {mplr_ff[MAG_BITS-2:0], 1'b0};
               cnt_ff  <= cnt_ff - 1'b1;
            end
         end
         FIN_MUL_B: begin
            mplr_ff <= {mplr_ff[MAG_BITS-2:0], 1'b0};
            acc_ff  <= acc_in;
            cnt_ff  <= cnt_ff - 1'b1;
         end
         FIN_SUB: begin
            rad_ff  <= {prod_a_ff - acc_ff, 16'b0};
            root_ff <= '0;
            srem_ff <= '0;
            cnt_ff  <= CNT_BITS'(ROOT_BITS - 1);
         end
         FIN_ROOT: begin
            rad_ff  <= {rad_ff[RAD_BITS-3:0], 2'b00};
            root_ff <= root_in;
            srem_ff <= srem_in[ROOT_BITS:0];
            if (last_step) begin
               num_ff <= root_in;
               rem_ff <= '0;
               cnt_ff <= CNT_BITS'(NUM_BITS - 1);
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         FIN_DIV_SD: begin
            num_ff <= num_in;
            rem_ff <= rem_in[WEIGHT_BITS-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (last_step) begin
               std_ff <= (|num_in[NUM_BITS-1:OUT_BITS]) ? '1 : num_in[OUT_BITS-1:0];
            end
         end
         FIN_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FIN_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == FIN_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            FIN_IDLE: begin
               if (snap_valid) begin
                  state_ff <= snap_ok ? FIN_DIV_MEAN : FIN_EMIT;
               end
            end
            FIN_DIV_MEAN: begin
               if (last_step) begin
                  state_ff <= FIN_MEAN;
               end
            end
            FIN_MEAN: begin
               state_ff <= FIN_MUL_A;
            end
            FIN_MUL_A: begin
               if (last_step) begin
                  state_ff <= FIN_MUL_B;
               end
            end
            FIN_MUL_B: begin
               if (last_step) begin
                  state_ff <= FIN_SUB;
               end
            end
            FIN_SUB: begin
               // No spread left when the squared mean term is not below the square term.
               state_ff <= (prod_a_ff > acc_ff) ? FIN_ROOT : FIN_EMIT;
            end
            FIN_ROOT: begin
               if (last_step) begin
                  state_ff <= FIN_DIV_SD;
               end
            end
            FIN_DIV_SD: begin
               if (last_step) begin
                  state_ff <= FIN_EMIT;
               end
            end
            FIN_EMIT: begin
               if (out_free) begin
                  state_ff <= FIN_IDLE;
               end
            end
            default: begin
               state_ff <= FIN_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == FIN_EMIT) && out_free) begin
         rsp_ok_ff   <= ok_ff;
         rsp_min_ff  <= min_ff;
         rsp_max_ff  <= max_ff;
         rsp_mean_ff <= mean_ff;
         rsp_std_ff  <= std_ff;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/time_weighted_range_stats_core.sv]
// Time weighted range statistics core.
// Samples of one sample-and-hold series enter on req_chan (valid/ready); a transfer
// takes one sample. Each held value is weighted by how long it lasts inside the window
// [range_start, range_end] set through the csr_ write port; it is to be written only
// while the core is idle, which the core itself does not enforce. The sample marked
// last closes the series and one result (min, max, mean and standard deviation in fixed
// point) later leaves on rsp_chan. Throughput: one sample a cycle while the queue has
// room; after a last sample no sample is taken until its closing command is pushed.
// After the sums are handed over the finishing unit divides for the mean, multiplies
// twice with its shift-add multiplier, takes the square root and divides once more
// for the standard deviation. The accumulator is a pipeline (p1, p2, p3).
// While a series is being finished the queue holds further interval commands; once it
// is full req_chan.ready drops until the sums have been handed over.
// A result waiting for rsp_chan.ready stays stable; the finishing unit then waits
// before it delivers the next result, and samples keep flowing until the queue fills.
// Reset (synchronous, active high) clears the window to its full range and drops all
// series state, queued commands and any pending result.
// Depends on twrs_pkg, twrs_req_if, twrs_rsp_if and the four sub-blocks.
`default_nettype none

module time_weighted_range_stats_core import twrs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   twrs_req_if.sink                  req_chan,
   twrs_rsp_if.source                rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [TIME_BITS-1:0] range_start_ff;
   logic [TIME_BITS-1:0] range_end_ff;

   logic          q_push, q_full, q_pop, q_empty;
   twrs_cmd_type  q_push_cmd, q_head_cmd;
   logic          snap_valid, snap_take;
   twrs_snap_type snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff <= '0;
         range_end_ff   <= '1;
      end else if (csr_we) begin
         unique case (twrs_csr_type'(csr_index))
            CSR_RANGE_START: range_start_ff <= csr_wdata;
            CSR_RANGE_END:   range_end_ff   <= csr_wdata;
         endcase
      end
   end

   twrs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .range_start (range_start_ff),
      .range_end   (range_end_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_push_cmd)
   );

   twrs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (q_head_cmd)
   );

   twrs_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head_cmd),
      .q_pop      (q_pop),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take)
   );

   twrs_final u_final (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[hw/rtl/twrs_checker.sv]
// Port checker of the time weighted range statistics core and the bind that attaches it.
// Depends on twrs_pkg and the assertion macros in time_weighted_range_stats_core_defines.svh.
`default_nettype none
`include "time_weighted_range_stats_core_defines.svh"

module twrs_checker import twrs_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         stats_valid,
   input logic signed [VALUE_BITS-1:0] lowest,
   input logic signed [VALUE_BITS-1:0] highest,
   input logic signed [OUT_BITS-1:0]   mean_value,
   input logic [OUT_BITS-1:0]          std_value
);

   `TWRS_ASSERT_NEXT_ALWAYS(a_no_result_after_reset, clock, reset, !rsp_valid, "result after reset")
   `TWRS_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `TWRS_ASSERT_NEXT(a_result_stable, clock, reset, rsp_valid && !rsp_ready, $stable({stats_valid, lowest, highest, mean_value, std_value}), "result changed while stalled")
   `TWRS_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !stats_valid, (lowest == '0) && (highest == '0) && (mean_value == '0) && (std_value == '0), "invalid result not zero")
   `TWRS_ASSERT_NOW(a_min_le_max, clock, reset, rsp_valid && stats_valid, lowest <= highest, "minimum above maximum")

endmodule

bind time_weighted_range_stats_core twrs_checker u_twrs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .stats_valid (rsp_chan.stats_valid),
   .lowest      (rsp_chan.lowest),
   .highest     (rsp_chan.highest),
   .mean_value  (rsp_chan.mean_value),
   .std_value   (rsp_chan.std_value)
);

`default_nettype wire

[dv/time_weighted_range_stats_core_tb.sv]
// Self-checking testbench of time_weighted_range_stats_core: series of samples go in, and
// each result is checked against a built-in predictor of the time weighted statistics.
// Depends on twrs_pkg, twrs_req_if, twrs_rsp_if and the core itself.
`timescale 1ns / 1ps

module time_weighted_range_stats_core_tb;
   import twrs_pkg::*;

   typedef struct {
      logic [TIME_BITS-1:0]         t;
      logic signed [VALUE_BITS-1:0] v;
      logic                         ok;
      logic                         last;
   } sample_type;

   typedef struct {
      logic                         ok;
      logic signed [VALUE_BITS-1:0] mn;
      logic signed [VALUE_BITS-1:0] mx;
      logic [OUT_BITS-1:0]          mean;
      logic [OUT_BITS-1:0]          sd;
   } stats_type;

   localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
   localparam logic [OUT_BITS-1:0] STD_TOP = '1;
   localparam int TAIL_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_RANGE_START;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   twrs_req_if req_chan();
   twrs_rsp_if rsp_chan();

   time_weighted_range_stats_core u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sample_type pending_samples[$];
   stats_type stats_due[$];
   int mismatches = 0;
   int items_queued = 0;

   // Window as the core should currently see it.
   logic [TIME_BITS-1:0] win_start = '0;
   logic [TIME_BITS-1:0] win_end = TIME_TOP;

   // Series state of the predictor.
   logic                         start_seen, beyond_end, hold_ok;
   logic signed [VALUE_BITS-1:0] hold_value, low_value, high_value, first_value;
   logic [TIME_BITS-1:0]         hold_from;
   logic [WEIGHT_BITS-1:0]       total_weight;
   logic [DEV_BITS-1:0]          dev_acc;
   logic [SQ_BITS-1:0]           sq_acc;

   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r, c;
      logic [127:0] cc;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         cc = c;
         if (cc * cc <= n) r = c;
      end
      return r;
   endfunction

   task automatic clear_series();
      start_seen = 1'b0;
      beyond_end = 1'b0;
      hold_ok = 1'b0;
      hold_value = '0;
      hold_from = '0;
      low_value = VALUE_MAX;
      high_value = VALUE_MIN;
      total_weight = '0;
      dev_acc = '0;
      sq_acc = '0;
      first_value = '0;
   endtask

   task automatic weigh_interval(logic signed [VALUE_BITS-1:0] v, logic ok, longint dt);
      longint d;
      if (dt == 0 || !ok) return;
      if (total_weight == 0) first_value = v;
      if (v < low_value) low_value = v;
      if (v > high_value) high_value = v;
      d = longint'(v) - longint'(first_value);
      total_weight = total_weight + WEIGHT_BITS'(dt);
      dev_acc = dev_acc + DEV_BITS'(d * dt);
      sq_acc = sq_acc + SQ_BITS'(d * d * dt);
   endtask

   task automatic close_series();
      stats_type s;
      logic signed [DEV_BITS-1:0] s1v;
      longint s1, m, lim;
      longint unsigned mag, q, w;
      logic [127:0] a, b;
      logic [63:0] r;
      s = '{default: '0};
      if (start_seen && win_end > hold_from)
         weigh_interval(hold_value, hold_ok, longint'(win_end) - longint'(hold_from));
      w = total_weight;
      if (start_seen && w > 0) begin
         s1v = dev_acc;
         s1 = s1v;
         mag = (s1 < 0) ? -s1 : s1;
         q = (mag << 8) / w;
         lim = 64'sd1 <<< (OUT_BITS - 1);
         if (s1 < 0) begin
            if (q * w != (mag << 8)) q++;
            m = longint'(first_value) * 256 - longint'(q);
         end else begin
            m = longint'(first_value) * 256 + longint'(q);
         end
         if (m > lim - 1) m = lim - 1;
         if (m < -lim) m = -lim;
         s.mean = OUT_BITS'(m);
         a = 128'(sq_acc) * 128'(w);
         b = 128'(mag) * 128'(mag);
         if (a > b) begin
            r = root_floor((a - b) << 16) / w;
            s.sd = (r > 64'(STD_TOP)) ? STD_TOP : OUT_BITS'(r);
         end
         s.ok = 1'b1;
         s.mn = low_value;
         s.mx = high_value;
      end
      stats_due.push_back(s);
      clear_series();
   endtask

   task automatic track_sample(sample_type s);
      if (!beyond_end) begin
         if (s.t > win_end) begin
            beyond_end = 1'b1;
         end else if (!start_seen) begin
            if (s.t <= win_start) begin
               start_seen = 1'b1;
               hold_value = s.v;
               hold_ok = s.ok;
               hold_from = win_start;
            end
         end else begin
            if (s.t > hold_from) begin
               weigh_interval(hold_value, hold_ok, longint'(s.t) - longint'(hold_from));
               hold_from = s.t;
            end
            hold_value = s.v;
            hold_ok = s.ok;
         end
      end
      if (s.last) close_series();
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      sample_type nx;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            track_sample('{req_chan.sample_time, req_chan.sample_value,
                           req_chan.value_valid, req_chan.last_sample});
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               nx = pending_samples.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.sample_time <= nx.t;
               req_chan.sample_value <= nx.v;
               req_chan.value_valid <= nx.ok;
               req_chan.last_sample <= nx.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready follows a rotating mask that is replaced now and then.
   logic [15:0] ready_mask = '1;
   int mask_age = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mask_age == 255) begin
            case ($urandom_range(0, 3))
               0: ready_mask = '1;
               1: ready_mask = 16'h0001;
               default: ready_mask = 16'($urandom);
            endcase
            if (ready_mask == 0) ready_mask = 16'h8000;
         end
         mask_age = (mask_age + 1) % 256;
         ready_mask = {ready_mask[14:0], ready_mask[15]};
         rsp_chan.ready <= ready_mask[0];
      end
   end

   // Result checker.
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (stats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
         end else begin
            e = stats_due.pop_front();
            if (rsp_chan.stats_valid !== e.ok || rsp_chan.lowest !== e.mn ||
                rsp_chan.highest !== e.mx || rsp_chan.mean_value !== e.mean ||
                rsp_chan.std_value !== e.sd) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected ok=%0b min=%0d max=%0d mean=%h std=%h,",
                            " got ok=%0b min=%0d max=%0d mean=%h std=%h"},
                           e.ok, e.mn, e.mx, e.mean, e.sd, rsp_chan.stats_valid,
                           rsp_chan.lowest, rsp_chan.highest, rsp_chan.mean_value,
                           rsp_chan.std_value);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel makes a transfer.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("time_weighted_range_stats_core_tb: FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic add_sample(logic [TIME_BITS-1:0] t, logic signed [VALUE_BITS-1:0] v,
                             logic ok, logic last);
      pending_samples.push_back('{t, v, ok, last});
      items_queued++;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_chan.valid || stats_due.size() > 0)
         @(posedge clock);
   endtask

   task automatic set_window(logic [TIME_BITS-1:0] s, logic [TIME_BITS-1:0] e);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_RANGE_START;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_RANGE_END;
      csr_wdata <= e;
      @(posedge clock);
      csr_we <= 1'b0;
      win_start = s;
      win_end = e;
   endtask

   // One series: mostly a proper start sample then rising times, sometimes noisy.
   task automatic make_series();
      int n;
      bit noisy, narrow;
      longint t, span, step_max;
      logic signed [VALUE_BITS-1:0] base, v;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10);
      noisy = ($urandom_range(0, 6) == 0);
      narrow = $urandom_range(0, 1);
      base = VALUE_BITS'($urandom);
      span = (win_end >= win_start) ? longint'(win_end) - longint'(win_start) : 0;
      step_max = span / n + 2;
      if ($urandom_range(0, 9) == 0)
         t = longint'(win_start) + $urandom_range(1, 50);
      else
         t = longint'(win_start) - $urandom_range(0, (win_start < 64) ? win_start : 64);
      for (int i = 0; i < n; i++) begin
         v = narrow ? base + VALUE_BITS'($urandom_range(0, 200)) - 16'sd100
                    : VALUE_BITS'($urandom);
         if (t > longint'(TIME_TOP)) t = TIME_TOP;
         add_sample(TIME_BITS'(t), v, $urandom_range(0, 9) != 0, i == n - 1);
         if (noisy && $urandom_range(0, 2) == 0)
            t = $urandom_range(0, 32'(TIME_TOP));
         else if ($urandom_range(0, 14) == 0)
            t = longint'(win_end) + $urandom_range(1, 100);
         else
            t = t + $urandom_range(0, 32'(step_max));
      end
   endtask

   initial begin
      logic [TIME_BITS-1:0] ws, we;
      bit drained_once;
      drained_once = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.sample_time = '0;
      req_chan.sample_value = '0;
      req_chan.value_valid = 1'b0;
      req_chan.last_sample = 1'b0;
      rsp_chan.ready = 1'b0;
      clear_series();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full window: lone last sample, extremes, an invalid hold, time running backward,
      // and a series with no sample at the window start.
      add_sample(0, 16'sh7fff, 1, 1);
      add_sample(0, 16'sh8000, 1, 0);
      add_sample(TIME_TOP, 16'sh7fff, 1, 1);
      add_sample(0, 7, 0, 0);
      add_sample(100, -5, 1, 0);
      add_sample(50, 9, 1, 0);
      add_sample(200, 3, 1, 1);
      add_sample(10, 1, 1, 0);
      add_sample(20, 2, 1, 1);

      // Narrow window: replaced start value, samples past the end, and no valid weight.
      set_window(1000, 5000);
      add_sample(500, 4, 1, 0);
      add_sample(900, 8, 1, 0);
      add_sample(3000, -100, 1, 0);
      add_sample(6000, 1, 1, 0);
      add_sample(7000, 2, 1, 1);
      add_sample(1000, 0, 0, 1);
      add_sample(TIME_TOP, 16'sh8000, 0, 1);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin ws = 0;        we = TIME_TOP; end
            1: begin ws = 0;        we = 0;        end
            2: begin ws = TIME_TOP; we = TIME_TOP; end
            3: begin ws = 5000;     we = 1000;     end
            7: begin ws = 1000;     we = 5000;     end
            default: begin
               ws = TIME_BITS'($urandom);
               we = (longint'(ws) + 65536 > longint'(TIME_TOP)) ? TIME_TOP
                       : TIME_BITS'(ws + $urandom_range(0, 65536));
            end
         endcase
         set_window(ws, we);
         items_queued = 0;
         while (items_queued < 165) begin
            make_series();
            // Once, hold the sender back until every result has come home.
            if (p == 4 && !drained_once && items_queued >= 80) begin
               wait_drained();
               drained_once = 1'b1;
            end
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("time_weighted_range_stats_core_tb: PASS");
      else
         $display("time_weighted_range_stats_core_tb: FAIL");
      $finish;
   end

endmodule
